FILE: hdl/goc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid obstacle collision check package
// Shared constants, register indexes and types for the collision checker.
// ----------------------------------------------------------------------------
package goc_pkg;

  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS    = 64;
  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = ADDR_W + 1;
  localparam int POS_W       = 14;
  localparam int ENTRY_W     = 2 * POS_W;
  localparam int IDX_W       = 7;
  localparam int WIDE_W      = 18;

  localparam logic [7:0]       OBSTACLE_CHAR = 8'h31;
  localparam logic [IDX_W-1:0] USED_COL_MAX  = IDX_W'(MAX_COLUMNS);
  localparam logic [IDX_W-1:0] USED_ROW_MAX  = IDX_W'(MAX_ROWS);

  typedef enum logic [1:0] {
    MODE_CHAR  = 2'd0,
    MODE_EOL   = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CAUSE_OK       = 2'd0,
    CAUSE_OVERLAP  = 2'd1,
    CAUSE_AREA     = 2'd2,
    CAUSE_NEGATIVE = 2'd3
  } cause_t;

  localparam logic [2:0] REG_AREA_WIDTH   = 3'd0;
  localparam logic [2:0] REG_AREA_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_CELL_WIDTH   = 3'd2;
  localparam logic [2:0] REG_CELL_HEIGHT  = 3'd3;
  localparam logic [2:0] REG_GRID_COLUMNS = 3'd4;
  localparam logic [2:0] REG_GRID_ROWS    = 3'd5;

  typedef struct packed {
    logic signed [15:0] ox;
    logic signed [15:0] oy;
    logic [11:0]        ow;
    logic [11:0]        oh;
  } query_t;

  typedef struct packed {
    logic [POS_W-1:0] bx;
    logic [POS_W-1:0] by;
    logic [7:0]       cw;
    logic [7:0]       ch;
  } box_t;

endpackage

FILE: hdl/goc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module goc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/goc_overlap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box overlap unit
// Strict overlap test of the query rectangle against one stored box.
// ----------------------------------------------------------------------------
module goc_overlap (
  input  goc_pkg::query_t query,
  input  goc_pkg::box_t   box,
  output logic            hit
);
  import goc_pkg::*;

  logic signed [WIDE_W-1:0] ox_e, oy_e, bx_e, by_e;
  logic signed [WIDE_W-1:0] bx_end, by_end, ox_end, oy_end;

  always_comb begin
    ox_e   = WIDE_W'(query.ox);
    oy_e   = WIDE_W'(query.oy);
    bx_e   = $signed({{(WIDE_W-POS_W){1'b0}}, box.bx});
    by_e   = $signed({{(WIDE_W-POS_W){1'b0}}, box.by});
    bx_end = bx_e + $signed({{(WIDE_W-8){1'b0}}, box.cw});
    by_end = by_e + $signed({{(WIDE_W-8){1'b0}}, box.ch});
    ox_end = ox_e + $signed({{(WIDE_W-12){1'b0}}, query.ow});
    oy_end = oy_e + $signed({{(WIDE_W-12){1'b0}}, query.oh});
    hit    = (ox_e < bx_end) && (bx_e < ox_end) && (oy_e < by_end) && (by_e < oy_end);
  end

endmodule

FILE: hdl/grid_obstacle_collision_check_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid obstacle collision check
// Builds an obstacle table from a character map and tests query rectangles.
// ----------------------------------------------------------------------------
// Map items are accepted whenever no query is in progress. A query walks the N
// stored obstacles (up to 4096 in all) through the table's single read port
// with one overlap unit, and a hit ends the walk early; no further item is
// accepted until the query's result item has been registered.
// Reset restores the register defaults and empties the table by clearing
// the obstacle count; table contents need no clearing pass.
module grid_obstacle_collision_check_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          mode,
  input  logic [7:0]          map_char,
  input  logic signed [15:0]  obj_x,
  input  logic signed [15:0]  obj_y,
  input  logic [11:0]         obj_w,
  input  logic [11:0]         obj_h,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                position_ok,
  output logic [1:0]          fail_cause,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [13:0]         cfg_data
);
  import goc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t state;

  logic [13:0]        area_width, area_height;
  logic [7:0]         cell_width, cell_height;
  logic [IDX_W-1:0]   grid_columns, grid_rows;
  logic [IDX_W-1:0]   column_index, row_index;
  logic [COUNT_W-1:0] obstacle_count;
  logic [COUNT_W-1:0] scan_addr;
  logic               rd_pend;
  logic               hit;
  query_t             query;

  logic [IDX_W-1:0]   used_cols, used_rows;
  logic               in_accept, in_grid, store;
  logic [14:0]        x_prod, y_prod;
  logic [ENTRY_W-1:0] wdata, rdata;
  logic               issuing, box_hit;
  box_t               box;
  logic signed [WIDE_W-1:0] x_end, y_end;
  cause_t             cause;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_accept = in_valid && in_ready;

  assign used_cols = (grid_columns < USED_COL_MAX) ? grid_columns : USED_COL_MAX;
  assign used_rows = (grid_rows < USED_ROW_MAX) ? grid_rows : USED_ROW_MAX;
  assign in_grid   = (row_index < used_rows) && (column_index < used_cols);
  assign store     = in_accept && (mode == MODE_CHAR) && in_grid &&
                     (map_char == OBSTACLE_CHAR) &&
                     (obstacle_count < COUNT_W'(TABLE_DEPTH));

  assign x_prod = 15'(column_index) * 15'(cell_width);
  assign y_prod = 15'(row_index) * 15'(cell_height);
  assign wdata  = {x_prod[POS_W-1:0], y_prod[POS_W-1:0]};

  assign issuing = (scan_addr < obstacle_count);

  goc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (store),
    .waddr (obstacle_count[ADDR_W-1:0]),
    .wdata (wdata),
    .raddr (scan_addr[ADDR_W-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    box.bx = rdata[ENTRY_W-1:POS_W];
    box.by = rdata[POS_W-1:0];
    box.cw = cell_width;
    box.ch = cell_height;
  end

  goc_overlap u_overlap (
    .query (query),
    .box   (box),
    .hit   (box_hit)
  );

  always_comb begin
    x_end = WIDE_W'(query.ox) + $signed({{(WIDE_W-12){1'b0}}, query.ow});
    y_end = WIDE_W'(query.oy) + $signed({{(WIDE_W-12){1'b0}}, query.oh});
    priority if (hit) begin
      cause = CAUSE_OVERLAP;
    end else if ((x_end > $signed({{(WIDE_W-14){1'b0}}, area_width})) ||
                 (y_end > $signed({{(WIDE_W-14){1'b0}}, area_height}))) begin
      cause = CAUSE_AREA;
    end else if (query.ox < 0 || query.oy < 0) begin
      cause = CAUSE_NEGATIVE;
    end else begin
      cause = CAUSE_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      area_width   <= 14'd2048;
      area_height  <= 14'd2048;
      cell_width   <= 8'd32;
      cell_height  <= 8'd32;
      grid_columns <= 7'd64;
      grid_rows    <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_AREA_WIDTH:   area_width   <= cfg_data;
        REG_AREA_HEIGHT:  area_height  <= cfg_data;
        REG_CELL_WIDTH:   cell_width   <= cfg_data[7:0];
        REG_CELL_HEIGHT:  cell_height  <= cfg_data[7:0];
        REG_GRID_COLUMNS: grid_columns <= cfg_data[IDX_W-1:0];
        REG_GRID_ROWS:    grid_rows    <= cfg_data[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      obstacle_count <= '0;
      column_index   <= '0;
      row_index      <= '0;
      scan_addr      <= '0;
      rd_pend        <= 1'b0;
      hit            <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            unique case (mode)
              MODE_CHAR: begin
                if (in_grid) begin
                  column_index <= column_index + 1'b1;
                end
                if (store) begin
                  obstacle_count <= obstacle_count + 1'b1;
                end
              end
              MODE_EOL: begin
                column_index <= '0;
                if (row_index < used_rows) begin
                  row_index <= row_index + 1'b1;
                end
              end
              MODE_QUERY: begin
                query     <= '{ox: obj_x, oy: obj_y, ow: obj_w, oh: obj_h};
                hit       <= 1'b0;
                scan_addr <= '0;
                rd_pend   <= 1'b0;
                if (obj_w == '0 || obj_h == '0 || obstacle_count == '0) begin
                  state <= ST_FINISH;
                end else begin
                  state <= ST_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          rd_pend <= issuing;
          if (issuing) begin
            scan_addr <= scan_addr + 1'b1;
          end
          if (rd_pend && box_hit) begin
            hit   <= 1'b1;
            state <= ST_FINISH;
          end else if (!issuing && !rd_pend) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid || out_ready) begin
            position_ok <= (cause == CAUSE_OK);
            fail_cause  <= cause;
            out_valid   <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_ok_matches_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (position_ok == (fail_cause == CAUSE_OK)))
    else $error("position_ok disagrees with fail_cause");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    obstacle_count <= COUNT_W'(TABLE_DEPTH))
    else $error("obstacle count beyond table depth");

  a_finish_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) |=> (state == ST_FINISH) || (out_valid && state == ST_IDLE))
    else $error("query finished without presenting a result");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (scan_addr <= obstacle_count))
    else $error("table walk passed the stored obstacles");

endmodule
